### design/mpeg_audio_header_decode_defines.svh
// Assertion macros for the MPEG audio header decoder top level.
`ifndef MPEG_AUDIO_HEADER_DECODE_DEFINES_SVH
`define MPEG_AUDIO_HEADER_DECODE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MAHD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MAHD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mahd_pkg.sv
// Types, constants and rate tables for the MPEG audio header decoder.
package mahd_pkg;

   localparam int SR_W  = 16;                 // sample rate, Hz
   localparam int BR_W  = 9;                  // bitrate, kbit/s
   localparam int QUO_W = 12;                 // quotient bits, one per cell
   localparam int NUM_W = 26;                 // k * bitrate < 2^26
   localparam int DSR_W = SR_W + QUO_W - 1;   // sample rate aligned to top quotient bit
   localparam int K_W   = 18;                 // 144000 fits

   // header field codes
   localparam logic [1:0] LAY_CODE_RSVD = 2'b00;
   localparam logic [3:0] BRI_BAD       = 4'hF;
   localparam logic [1:0] SRI_RSVD      = 2'b11;
   localparam logic [1:0] EMPH_RSVD     = 2'b10;
   localparam logic [1:0] MODE_DUAL     = 2'b10;
   localparam logic [1:0] MODE_MONO     = 2'b11;

   // decoded layer numbers
   localparam logic [1:0] LAYER_I   = 2'd1;
   localparam logic [1:0] LAYER_II  = 2'd2;
   localparam logic [1:0] LAYER_III = 2'd3;

   // channel layout codes
   localparam logic [1:0] LAYOUT_LR     = 2'd0;
   localparam logic [1:0] LAYOUT_DUAL   = 2'd1;
   localparam logic [1:0] LAYOUT_CENTER = 2'd2;

   localparam logic [K_W-1:0] K_LAYER_I  = K_W'(12000);
   localparam logic [K_W-1:0] K_FULL     = K_W'(144000);
   localparam logic [K_W-1:0] K_HALF     = K_W'(72000);

   localparam logic [10:0] SPF_384  = 11'd384;
   localparam logic [10:0] SPF_576  = 11'd576;
   localparam logic [10:0] SPF_1152 = 11'd1152;

   // [version: 0 MPEG-1, 1 MPEG-2][layer-1][bitrate index]
   localparam logic [BR_W-1:0] RATE_KBPS [2][3][16] = '{
      '{
         '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
      },
      '{
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
      }
   };

   // [version][rate index]
   localparam logic [SR_W-1:0] RATE_HZ [2][4] = '{
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0}
   };

   // divider lanes: current bitrate and top bitrate of the table
   typedef struct packed {
      logic [NUM_W-1:0] rem_cur;
      logic [NUM_W-1:0] rem_max;
      logic [DSR_W-1:0] dsr;
      logic [QUO_W-1:0] q_cur;
      logic [QUO_W-1:0] q_max;
   } div_type;

   // decoded fields riding along the divider
   typedef struct packed {
      logic            ok;
      logic [1:0]      layer;
      logic [1:0]      channels;
      logic [1:0]      layout;
      logic [SR_W-1:0] sample_rate;
      logic [BR_W-1:0] bit_rate;
      logic            pad;
      logic [10:0]     frame_samples;
   } side_type;

endpackage

### design/mahd_front.sv
// Header field decode, table lookup and numerator multiply stage.
module mahd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         header_word,
   output logic                out_valid,
   output mahd_pkg::div_type   out_div,
   output mahd_pkg::side_type  out_side
);

   logic                        vld_ff;
   mahd_pkg::div_type           div_ff, div_in;
   mahd_pkg::side_type          side_ff, side_in;

   logic                        half, ver, pad;
   logic [1:0]                  lay_code, lay, lay_idx, sri, mode, emph;
   logic [3:0]                  bri;
   logic                        reject;
   logic [mahd_pkg::BR_W-1:0]   br, brmax;
   logic [mahd_pkg::SR_W-1:0]   sr;
   logic [mahd_pkg::K_W-1:0]    k;
   logic [10:0]                 spf;
   logic [mahd_pkg::K_W+mahd_pkg::BR_W-1:0] prod_cur, prod_max;

   assign half     = ~header_word[20];
   assign ver      = ~header_word[19];
   assign lay_code = header_word[18:17];
   assign bri      = header_word[15:12];
   assign sri      = header_word[11:10];
   assign pad      = header_word[9];
   assign mode     = header_word[7:6];
   assign emph     = header_word[1:0];

   // layer = 4 - code; code 0 is reserved
   assign lay     = 2'(3'd4 - {1'b0, lay_code});
   assign lay_idx = (lay_code == mahd_pkg::LAY_CODE_RSVD) ? 2'd0 : 2'(lay - 2'd1);

   assign reject = (lay_code == mahd_pkg::LAY_CODE_RSVD) || (bri == mahd_pkg::BRI_BAD) ||
                   (sri == mahd_pkg::SRI_RSVD) || (emph == mahd_pkg::EMPH_RSVD);

   always_comb begin
      br    = mahd_pkg::RATE_KBPS[ver][lay_idx][bri];
      brmax = mahd_pkg::RATE_KBPS[ver][lay_idx][4'd14];
      sr    = mahd_pkg::RATE_HZ[ver][sri];
      if (half) begin
         sr = sr >> 1;
      end
      unique case (lay)
         mahd_pkg::LAYER_I: begin
            k   = mahd_pkg::K_LAYER_I;
            spf = mahd_pkg::SPF_384;
         end
         mahd_pkg::LAYER_II: begin
            k   = mahd_pkg::K_FULL;
            spf = mahd_pkg::SPF_1152;
         end
         default: begin
            k   = ver ? mahd_pkg::K_HALF : mahd_pkg::K_FULL;
            spf = ver ? mahd_pkg::SPF_576 : mahd_pkg::SPF_1152;
         end
      endcase
      prod_cur = k * br;
      prod_max = k * brmax;

      div_in.rem_cur = prod_cur[mahd_pkg::NUM_W-1:0];
      div_in.rem_max = prod_max[mahd_pkg::NUM_W-1:0];
      div_in.dsr     = {sr, {(mahd_pkg::QUO_W-1){1'b0}}};
      div_in.q_cur   = '0;
      div_in.q_max   = '0;

      side_in.ok            = ~reject;
      side_in.layer         = lay;
      side_in.channels      = (mode == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
      if (mode == mahd_pkg::MODE_MONO) begin
         side_in.layout = mahd_pkg::LAYOUT_CENTER;
      end else if (mode == mahd_pkg::MODE_DUAL) begin
         side_in.layout = mahd_pkg::LAYOUT_DUAL;
      end else begin
         side_in.layout = mahd_pkg::LAYOUT_LR;
      end
      side_in.sample_rate   = sr;
      side_in.bit_rate      = br;
      side_in.pad           = pad;
      side_in.frame_samples = spf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= div_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

### design/mahd_cell.sv
// One restoring-division cell: one quotient bit for each lane.
module mahd_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  mahd_pkg::div_type   in_div,
   input  mahd_pkg::side_type  in_side,
   output logic                out_valid,
   output mahd_pkg::div_type   out_div,
   output mahd_pkg::side_type  out_side
);

   logic                 vld_ff;
   mahd_pkg::div_type    div_ff, div_in;
   mahd_pkg::side_type   side_ff;
   logic                 ge_cur, ge_max;
   logic [mahd_pkg::DSR_W-1:0] ext_cur, ext_max;

   always_comb begin
      ext_cur = {1'b0, in_div.rem_cur};
      ext_max = {1'b0, in_div.rem_max};
      ge_cur  = (ext_cur >= in_div.dsr);
      ge_max  = (ext_max >= in_div.dsr);

      div_in.rem_cur = ge_cur ? mahd_pkg::NUM_W'(ext_cur - in_div.dsr) : in_div.rem_cur;
      div_in.rem_max = ge_max ? mahd_pkg::NUM_W'(ext_max - in_div.dsr) : in_div.rem_max;
      div_in.dsr     = in_div.dsr >> 1;
      div_in.q_cur   = {in_div.q_cur[mahd_pkg::QUO_W-2:0], ge_cur};
      div_in.q_max   = {in_div.q_max[mahd_pkg::QUO_W-2:0], ge_max};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= div_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = vld_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

### design/mpeg_audio_header_decode.sv
// Top level of the MPEG audio frame header decoder.
// Decodes one 32-bit MPEG audio layer I/II/III frame header per word: layer, channel
// count and layout, sample rate, bitrate, frame length in bytes, largest frame length
// (doubled for free bitrate) and samples per frame. A header with a reserved layer,
// bitrate index 15, rate index 3 or emphasis 2 comes out with valid_res low and all
// other fields zero; the sync word is not checked. Throughput is one word per cycle
// unless rsp_ready stalls the output. A word passes one decode/multiply stage, a
// chain of 12 divider cells that each resolve one bit of the two frame-length
// quotients (current and top bitrate over sample rate), and the output register.
// Each stage holds its word only while the stage after it is full and stalled, so
// while a finished result waits on rsp_ready, words are taken until every stage is full.
module mpeg_audio_header_decode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_header_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [1:0]  rsp_layer,
   output logic [1:0]  rsp_channels,
   output logic [1:0]  rsp_channel_layout,
   output logic [15:0] rsp_sample_rate,
   output logic [8:0]  rsp_bit_rate,
   output logic [11:0] rsp_frame_size,
   output logic [12:0] rsp_max_frame_size,
   output logic [10:0] rsp_frame_samples
);

`include "mpeg_audio_header_decode_defines.svh"

   localparam int NCELL = mahd_pkg::QUO_W;

   // stage 0 is the front stage, stages 1..NCELL the divider cells
   logic                vld      [0:NCELL];
   mahd_pkg::div_type   div_arr  [0:NCELL];
   mahd_pkg::side_type  side_arr [0:NCELL];
   logic                rdy      [0:NCELL+1];

   logic rsp_valid_ff;
   logic rsp_ok_ff, rsp_ok_in;
   logic [1:0]  layer_ff, layer_in, chan_ff, chan_in, layout_ff, layout_in;
   logic [15:0] sr_ff, sr_in;
   logic [8:0]  br_ff, br_in;
   logic [11:0] fs_ff, fs_in;
   logic [12:0] mfs_ff, mfs_in;
   logic [10:0] spf_ff, spf_in;

   logic [12:0] cur_sum, max_sum;
   logic [14:0] fs_full;
   logic [15:0] mfs_base, mfs_full;
   logic        lay1, free;

   // ready ripples back: a stage can load when it is empty or its successor loads
   assign rdy[NCELL+1] = ~rsp_valid_ff | rsp_ready;
   for (genvar i = 0; i <= NCELL; i++) begin : g_rdy
      assign rdy[i] = ~vld[i] | rdy[i+1];
   end
   assign req_ready = rdy[0];

   mahd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (rdy[0]),
      .in_valid    (req_valid),
      .header_word (req_header_word),
      .out_valid   (vld[0]),
      .out_div     (div_arr[0]),
      .out_side    (side_arr[0])
   );

   for (genvar j = 1; j <= NCELL; j++) begin : g_cell
      mahd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (rdy[j]),
         .in_valid  (vld[j-1]),
         .in_div    (div_arr[j-1]),
         .in_side   (side_arr[j-1]),
         .out_valid (vld[j]),
         .out_div   (div_arr[j]),
         .out_side  (side_arr[j])
      );
   end

   // frame sizes from the quotients; layer I counts 4-byte slots
   always_comb begin
      lay1     = (side_arr[NCELL].layer == mahd_pkg::LAYER_I);
      free     = (side_arr[NCELL].bit_rate == '0);
      cur_sum  = 13'(div_arr[NCELL].q_cur) + 13'(side_arr[NCELL].pad);
      max_sum  = 13'(div_arr[NCELL].q_max) + 13'd1;
      fs_full  = lay1 ? {cur_sum, 2'b00} : 15'(cur_sum);
      mfs_base = lay1 ? {1'b0, max_sum, 2'b00} : 16'(max_sum);
      mfs_full = free ? (mfs_base << 1) : mfs_base;

      rsp_ok_in = side_arr[NCELL].ok;
      if (side_arr[NCELL].ok) begin
         layer_in  = side_arr[NCELL].layer;
         chan_in   = side_arr[NCELL].channels;
         layout_in = side_arr[NCELL].layout;
         sr_in     = side_arr[NCELL].sample_rate;
         br_in     = side_arr[NCELL].bit_rate;
         fs_in     = fs_full[11:0];
         mfs_in    = mfs_full[12:0];
         spf_in    = side_arr[NCELL].frame_samples;
      end else begin
         layer_in  = '0;
         chan_in   = '0;
         layout_in = '0;
         sr_in     = '0;
         br_in     = '0;
         fs_in     = '0;
         mfs_in    = '0;
         spf_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy[NCELL+1]) begin
         rsp_valid_ff <= vld[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NCELL+1]) begin
         rsp_ok_ff <= rsp_ok_in;
         layer_ff  <= layer_in;
         chan_ff   <= chan_in;
         layout_ff <= layout_in;
         sr_ff     <= sr_in;
         br_ff     <= br_in;
         fs_ff     <= fs_in;
         mfs_ff    <= mfs_in;
         spf_ff    <= spf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_res      = rsp_ok_ff;
   assign rsp_layer          = layer_ff;
   assign rsp_channels       = chan_ff;
   assign rsp_channel_layout = layout_ff;
   assign rsp_sample_rate    = sr_ff;
   assign rsp_bit_rate       = br_ff;
   assign rsp_frame_size     = fs_ff;
   assign rsp_max_frame_size = mfs_ff;
   assign rsp_frame_samples  = spf_ff;

   `MAHD_ASSERT_IMP(a_reject_zero, rsp_valid && !rsp_valid_res,
      rsp_layer == 2'd0 && rsp_sample_rate == 16'd0 && rsp_frame_size == 12'd0 &&
      rsp_max_frame_size == 13'd0 && rsp_frame_samples == 11'd0,
      "rejected header word carries nonzero fields")
   `MAHD_ASSERT_IMP(a_spf_legal, rsp_valid && rsp_valid_res,
      rsp_frame_samples == 11'd384 || rsp_frame_samples == 11'd576 ||
      rsp_frame_samples == 11'd1152,
      "illegal samples per frame")
   // free bitrate leaves only the padding: one byte, or one 4-byte slot in layer I
   `MAHD_ASSERT_IMP(a_free_size, rsp_valid && rsp_valid_res && rsp_bit_rate == 9'd0,
      rsp_frame_size <= 12'd4, "free bitrate word with frame size beyond padding")
   `MAHD_ASSERT_IMP(a_sr_nonzero, rsp_valid && rsp_valid_res,
      rsp_sample_rate != 16'd0, "legal header word with zero sample rate")
   `MAHD_ASSERT_NXT(a_tail_hold, vld[NCELL] && !rdy[NCELL+1],
      vld[NCELL] && $stable(div_arr[NCELL].q_cur), "last cell lost word under stall")

endmodule
